FILE: sv/tmni_pkg.sv
// Shared types, widths and the neighbour offset table of the tetrahedral mesh neighbour unit.
// No dependencies; every other file but tmni_fifo imports this package.
package tmni_pkg;

	localparam int IDX_W      = 21;
	localparam int NODE_W     = 3;
	localparam int QW         = IDX_W - NODE_W;
	localparam int DIM_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int PORTS      = 4;
	localparam int PORT_W     = IDX_W + 1;
	localparam int BPS        = 2;
	localparam int DIV_STAGES = (QW + BPS - 1) / BPS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIM_X = 2'd0,
		REG_DIM_Y = 2'd1,
		REG_DIM_Z = 2'd2
	} cfg_reg_t;

	// Cube offsets are two-bit two's complement.
	localparam logic [1:0] OZ = 2'b00;
	localparam logic [1:0] OP = 2'b01;
	localparam logic [1:0] OM = 2'b11;

	typedef struct packed {
		logic [1:0]        dx;
		logic [1:0]        dy;
		logic [1:0]        dz;
		logic [NODE_W-1:0] tn;
	} nbr_t;

	function automatic nbr_t mk(input logic [1:0] a, input logic [1:0] b,
			input logic [1:0] c, input logic [NODE_W-1:0] n);
		nbr_t e;
		e.dx = a;
		e.dy = b;
		e.dz = c;
		e.tn = n;
		return e;
	endfunction

	// Entry (node, k) sits at case code node*4 + k.
	function automatic nbr_t nbr_lookup(input logic [NODE_W-1:0] node, input logic [1:0] k);
		nbr_t e;
		case ({node, k})
			5'd0:  e = mk(OZ, OZ, OZ, 3'd2);
			5'd1:  e = mk(OM, OZ, OM, 3'd3);
			5'd2:  e = mk(OZ, OM, OM, 3'd6);
			5'd3:  e = mk(OM, OM, OZ, 3'd7);
			5'd4:  e = mk(OZ, OZ, OZ, 3'd2);
			5'd5:  e = mk(OZ, OZ, OZ, 3'd3);
			5'd6:  e = mk(OZ, OM, OZ, 3'd6);
			5'd7:  e = mk(OZ, OM, OZ, 3'd7);
			5'd8:  e = mk(OZ, OZ, OZ, 3'd0);
			5'd9:  e = mk(OZ, OZ, OZ, 3'd1);
			5'd10: e = mk(OZ, OZ, OZ, 3'd4);
			5'd11: e = mk(OZ, OZ, OZ, 3'd5);
			5'd12: e = mk(OP, OZ, OP, 3'd0);
			5'd13: e = mk(OZ, OZ, OZ, 3'd1);
			5'd14: e = mk(OP, OZ, OZ, 3'd4);
			5'd15: e = mk(OZ, OZ, OP, 3'd5);
			5'd16: e = mk(OZ, OZ, OZ, 3'd2);
			5'd17: e = mk(OM, OZ, OZ, 3'd3);
			5'd18: e = mk(OZ, OZ, OZ, 3'd6);
			5'd19: e = mk(OM, OZ, OZ, 3'd7);
			5'd20: e = mk(OZ, OZ, OZ, 3'd2);
			5'd21: e = mk(OZ, OZ, OM, 3'd3);
			5'd22: e = mk(OZ, OZ, OM, 3'd6);
			5'd23: e = mk(OZ, OZ, OZ, 3'd7);
			5'd24: e = mk(OZ, OP, OP, 3'd0);
			5'd25: e = mk(OZ, OP, OZ, 3'd1);
			5'd26: e = mk(OZ, OZ, OZ, 3'd4);
			5'd27: e = mk(OZ, OZ, OP, 3'd5);
			5'd28: e = mk(OP, OP, OZ, 3'd0);
			5'd29: e = mk(OZ, OP, OZ, 3'd1);
			5'd30: e = mk(OP, OZ, OZ, 3'd4);
			5'd31: e = mk(OZ, OZ, OZ, 3'd5);
			default: e = mk(OZ, OZ, OZ, 3'd0);
		endcase
		return e;
	endfunction

endpackage

FILE: sv/tetra_mesh_neighbor_index_top.sv
// Tetrahedral mesh neighbour index unit: top level with configuration registers and queues.
// Depends on tmni_pkg, tmni_fifo, tmni_front and tmni_back.
//
// Push a flat node index and pop the four neighbour indices of that node
// with a valid bit each; a neighbour whose cube falls outside the dim_x by dim_y by dim_z grid
// comes back invalid with index zero, and so do all four while any dimension is zero.
// Dimensions above MAX_DIM are taken as MAX_DIM, and the cube z wraps modulo dim_z. One word
// is taken every cycle for as long as pop keeps up; a word spends three divider pipelines of
// nine stages each (two quotient bits per stage, one pipeline per axis), a queue, two
// multiply stages and the result queue before it shows on the result ports.
// The configuration channel is always ready; write dim_x, dim_y and dim_z (indices 0, 1, 2)
// only while nothing is in flight. Writes to index 3 are dropped. All dimensions reset to 1.
module tetra_mesh_neighbor_index_top #(
	parameter int MAX_DIM = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [tmni_pkg::IDX_W-1:0]      node_index,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tmni_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmni_pkg::DIM_W-1:0]      cfg_data,
	output logic                            empty,
	input  logic                            pop,
	output logic [tmni_pkg::IDX_W-1:0]      port0_index,
	output logic                            port0_valid,
	output logic [tmni_pkg::IDX_W-1:0]      port1_index,
	output logic                            port1_valid,
	output logic [tmni_pkg::IDX_W-1:0]      port2_index,
	output logic                            port2_valid,
	output logic [tmni_pkg::IDX_W-1:0]      port3_index,
	output logic                            port3_valid
);
	import tmni_pkg::*;

	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int MW    = NODE_W + 3 * DW;
	localparam int OW    = PORTS * PORT_W;
	localparam int INFL  = 3 * DIV_STAGES + 8;
	localparam int CNTW  = $clog2(INFL + 1);

	logic [DIM_W-1:0] dim_x_q;
	logic [DIM_W-1:0] dim_y_q;
	logic [DIM_W-1:0] dim_z_q;
	logic [DW-1:0]    dx;
	logic [DW-1:0]    dy;
	logic [DW-1:0]    dz;

	logic          m_push;
	logic          m_full;
	logic [MW-1:0] m_din;
	logic          m_pop;
	logic          m_empty;
	logic [MW-1:0] m_dout;
	logic          o_push;
	logic          o_full;
	logic [OW-1:0] o_din;
	logic [OW-1:0] o_dout;
	logic [CNTW-1:0] inflight_q;

	// Configuration: always ready, index beyond the register list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= DIM_W'(1);
			dim_y_q <= DIM_W'(1);
			dim_z_q <= DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DIM_X: dim_x_q <= cfg_data;
				REG_DIM_Y: dim_y_q <= cfg_data;
				REG_DIM_Z: dim_z_q <= cfg_data;
				default:   dim_x_q <= dim_x_q;
			endcase
		end
	end

	// Saturate each dimension at MAX_DIM.
	assign dx = (32'(dim_x_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_x_q);
	assign dy = (32'(dim_y_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_y_q);
	assign dz = (32'(dim_z_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_z_q);

	// Front: split the index into node and cube coordinates.
	tmni_front #(.DW(DW)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .node_index(node_index),
		.dim_x(dx), .dim_y(dy), .dim_z(dz),
		.q_full(m_full), .q_push(m_push), .q_data(m_din)
	);

	// Decouple the divider chain from the neighbour stages.
	tmni_fifo #(.W(MW)) u_mid_q (
		.clk(clk), .arst_n(arst_n), .push(m_push), .full(m_full), .din(m_din),
		.pop(m_pop), .empty(m_empty), .dout(m_dout)
	);

	// Back: offsets, range checks and flat neighbour indices.
	tmni_back #(.DW(DW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(m_empty), .q_pop(m_pop), .q_data(m_dout),
		.dim_x(dx), .dim_y(dy), .dim_z(dz),
		.o_full(o_full), .o_push(o_push), .o_data(o_din)
	);

	// Result queue: holds finished words while the consumer stalls.
	tmni_fifo #(.W(OW)) u_out_q (
		.clk(clk), .arst_n(arst_n), .push(o_push), .full(o_full), .din(o_din),
		.pop(pop), .empty(empty), .dout(o_dout)
	);

	assign {port0_valid, port0_index} = o_dout[0*PORT_W +: PORT_W];
	assign {port1_valid, port1_index} = o_dout[1*PORT_W +: PORT_W];
	assign {port2_valid, port2_index} = o_dout[2*PORT_W +: PORT_W];
	assign {port3_valid, port3_index} = o_dout[3*PORT_W +: PORT_W];

	// Count words taken in and not yet popped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({push && !full, pop && !empty})
				2'b10:   inflight_q <= inflight_q + CNTW'(1);
				2'b01:   inflight_q <= inflight_q - CNTW'(1);
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	a_pop_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |-> (inflight_q != '0))
		else $error("result popped with no word in flight");

	a_idle_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> empty)
		else $error("result shown with no word in flight");

	a_zero_dim_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ((dx == '0) || (dy == '0) || (dz == '0)))
		|-> (!port0_valid && !port1_valid && !port2_valid && !port3_valid))
		else $error("neighbour valid with a zero dimension");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((port0_valid || port0_index == '0) && (port1_valid || port1_index == '0)
			&& (port2_valid || port2_index == '0) && (port3_valid || port3_index == '0)))
		else $error("invalid neighbour carries a nonzero index");

endmodule

FILE: sv/tmni_fifo.sv
// Two-entry word queue used between the front and back halves and on the result side.
// Depends on nothing but the clock and reset.
module tmni_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] dout
);

	logic [W-1:0] data_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = data_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) data_q[wptr_q] <= din;
	end

endmodule

FILE: sv/tmni_div.sv
// Pipelined restoring divider, BPS quotient bits per stage, with a sideband payload.
// Uses tmni_pkg BPS; user keeps divisor static while words are in flight, unchecked.
module tmni_div #(
	parameter int N  = 18,
	parameter int DW = 7,
	parameter int PW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [N-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	input  logic [PW-1:0] in_pl,
	output logic          out_valid,
	output logic [N-1:0]  quo,
	output logic [DW-1:0] rem,
	output logic [PW-1:0] out_pl
);
	import tmni_pkg::*;

	localparam int S  = (N + BPS - 1) / BPS;
	localparam int NP = S * BPS;

	logic          vld_s [S];
	logic [DW-1:0] rem_s [S];
	logic [NP-1:0] dq_s  [S];
	logic [PW-1:0] pl_s  [S];

	for (genvar i = 0; i < S; i++) begin : g_stage
		logic          v_in;
		logic [DW-1:0] r_in;
		logic [NP-1:0] d_in;
		logic [PW-1:0] p_in;
		logic [DW-1:0] r_nx;
		logic [NP-1:0] d_nx;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = '0;
			assign d_in = NP'(dividend);
			assign p_in = in_pl;
		end else begin : g_next
			assign v_in = vld_s[i-1];
			assign r_in = rem_s[i-1];
			assign d_in = dq_s[i-1];
			assign p_in = pl_s[i-1];
		end

		// Shift in the next dividend bit; subtract where the divisor fits.
		always_comb begin
			logic [DW:0]   rt;
			logic [DW-1:0] r;
			logic [NP-1:0] d;
			r = r_in;
			d = d_in;
			for (int j = 0; j < BPS; j++) begin
				rt = {r, d[NP-1]};
				d  = {d[NP-2:0], 1'b0};
				if (rt >= {1'b0, divisor}) begin
					rt   = rt - {1'b0, divisor};
					d[0] = 1'b1;
				end
				r = rt[DW-1:0];
			end
			r_nx = r;
			d_nx = d;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= r_nx;
				dq_s[i]  <= d_nx;
				pl_s[i]  <= p_in;
			end
		end
	end

	assign out_valid = vld_s[S-1];
	assign quo       = dq_s[S-1][N-1:0];
	assign rem       = rem_s[S-1];
	assign out_pl    = pl_s[S-1];

endmodule

FILE: sv/tmni_front.sv
// Front half: accept node indices and split them into node-in-cube and cube x, y, z.
// Uses tmni_pkg, tmni_div; stalls as one when an output word meets a full mid queue.
module tmni_front #(
	parameter int DW = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [tmni_pkg::IDX_W-1:0] node_index,
	input  logic [DW-1:0]             dim_x,
	input  logic [DW-1:0]             dim_y,
	input  logic [DW-1:0]             dim_z,
	input  logic                      q_full,
	output logic                      q_push,
	output logic [tmni_pkg::NODE_W+3*DW-1:0] q_data
);
	import tmni_pkg::*;

	logic              en;
	logic              a_valid;
	logic              b_valid;
	logic              c_valid;
	logic [QW-1:0]     qa;
	logic [QW-1:0]     qb;
	logic [DW-1:0]     cx;
	logic [DW-1:0]     cy;
	logic [DW-1:0]     cz;
	logic [NODE_W-1:0] a_node;
	logic [NODE_W+DW-1:0]   b_pl;
	logic [NODE_W+2*DW-1:0] c_pl;

	// Hold every stage while the last one has a word that the queue cannot take.
	assign en     = !(c_valid && q_full);
	assign full   = !en;
	assign q_push = c_valid && !q_full;
	assign q_data = {c_pl, cz};

	tmni_div #(.N(QW), .DW(DW), .PW(NODE_W)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(push && en), .dividend(node_index[IDX_W-1:NODE_W]), .divisor(dim_x),
		.in_pl(node_index[NODE_W-1:0]),
		.out_valid(a_valid), .quo(qa), .rem(cx), .out_pl(a_node)
	);

	tmni_div #(.N(QW), .DW(DW), .PW(NODE_W+DW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(a_valid), .dividend(qa), .divisor(dim_y), .in_pl({a_node, cx}),
		.out_valid(b_valid), .quo(qb), .rem(cy), .out_pl(b_pl)
	);

	tmni_div #(.N(QW), .DW(DW), .PW(NODE_W+2*DW)) u_div_z (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(b_valid), .dividend(qb), .divisor(dim_z), .in_pl({b_pl, cy}),
		.out_valid(c_valid), .quo(), .rem(cz), .out_pl(c_pl)
	);

endmodule

FILE: sv/tmni_back.sv
// Back half: apply the offset table to a split index and form four neighbour indices.
// Depends on tmni_pkg; two stages, one multiply each, stalled by the result queue.
module tmni_back #(
	parameter int DW = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	output logic                      q_pop,
	input  logic [tmni_pkg::NODE_W+3*DW-1:0] q_data,
	input  logic [DW-1:0]             dim_x,
	input  logic [DW-1:0]             dim_y,
	input  logic [DW-1:0]             dim_z,
	input  logic                      o_full,
	output logic                      o_push,
	output logic [tmni_pkg::PORTS*tmni_pkg::PORT_W-1:0] o_data
);
	import tmni_pkg::*;

	logic              en;
	logic              zero_dim;
	logic [NODE_W-1:0] node;
	logic [DW-1:0]     cx;
	logic [DW-1:0]     cy;
	logic [DW-1:0]     cz;

	logic              vld_s1;
	logic              ok_s1 [PORTS];
	logic [DW-1:0]     sx_s1 [PORTS];
	logic [QW-1:0]     t_s1  [PORTS];
	logic [NODE_W-1:0] tn_s1 [PORTS];
	logic              vld_s2;
	logic [PORTS*PORT_W-1:0] word_s2;

	assign {node, cx, cy, cz} = q_data;
	assign zero_dim = (dim_x == '0) || (dim_y == '0) || (dim_z == '0);
	assign en       = !(vld_s2 && o_full);
	assign q_pop    = !q_empty && en;
	assign o_push   = vld_s2 && !o_full;
	assign o_data   = word_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= !q_empty;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar k = 0; k < PORTS; k++) begin : g_port
		nbr_t        e;
		logic [DW:0] sx;
		logic [DW:0] sy;
		logic [DW:0] sz;
		logic [QW-1:0] xs;

		// A step below zero wraps to all ones, which no dimension reaches.
		assign e  = nbr_lookup(node, 2'(k));
		assign sx = {1'b0, cx} + (DW+1)'(signed'(e.dx));
		assign sy = {1'b0, cy} + (DW+1)'(signed'(e.dy));
		assign sz = {1'b0, cz} + (DW+1)'(signed'(e.dz));
		assign xs = QW'(sx_s1[k]) + QW'(dim_x) * t_s1[k];

		always_ff @(posedge clk) begin
			if (en) begin
				ok_s1[k] <= !zero_dim && (sx < {1'b0, dim_x}) && (sy < {1'b0, dim_y})
					&& (sz < {1'b0, dim_z});
				sx_s1[k] <= sx[DW-1:0];
				t_s1[k]  <= QW'(sy) + QW'(dim_y) * QW'(sz);
				tn_s1[k] <= e.tn;
				word_s2[k*PORT_W +: PORT_W] <= ok_s1[k] ? {1'b1, xs, tn_s1[k]} : '0;
			end
		end
	end

endmodule
